// ===== design/rfcc_pkg.sv =====
package rfcc_pkg;

    // Default limit on the number of bytes that take part in the check.
    localparam int MAX_FRAME_BYTES_DEF = 256;

    // CRC-16 generator polynomial, register shifting left.
    localparam logic [15:0] CRC_POLY = 16'h8005;

    // Frame status codes reported on the last byte of a burst.
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_CRC_ERR  = 2'd1,
        STATUS_LEN_ERR  = 2'd2,
        STATUS_OVERRUN  = 2'd3
    } frame_status_t;

    // One received byte with its end-of-burst flag.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       burst_end;
    } rx_item_t;

    // Result of checking one byte.
    typedef struct packed {
        logic          out_last;
        frame_status_t frame_status;
    } check_res_t;

    // Feed one byte into the CRC, least significant bit first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] crc;
        logic        fb;
        crc = crc_in;
        for (int i = 0; i < 8; i++) begin
            fb  = data[i] ^ crc[15];
            crc = {crc[14:0], 1'b0};
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

// ===== design/response_frame_crc_checker_top.sv =====
// Response frame CRC checker.
// The slave channel takes one received response byte per transfer in
// s_tdata, with s_tlast on the last byte of the burst. Byte 0 carries the
// frame count N; a CRC-16 (polynomial 0x8005, start value 0, bits fed LSB
// first) over bytes 0 to N-3 must match bytes N-2 (low) and N-1 (high).
// The master channel returns every byte unchanged with the same tlast; on
// the last byte m_tuser carries the frame status: ok, CRC mismatch, length
// error or buffer overrun (more than MAX_FRAME_BYTES bytes in the burst).
// An input transfer reaches its shown result through an input register and
// a result register. Throughput is one byte per cycle while the receiver
// takes results: the whole CRC byte step sits between the two registers.
// Reset clears both valid flags and the frame state; no clearing pass is
// needed. When the receiver stalls, the result register holds and the
// input register still takes one more byte, after which s_tready falls
// until the result is taken.
module response_frame_crc_checker_top #(
    parameter int MAX_FRAME_BYTES = rfcc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] rx_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic       m_tlast,
    output logic [1:0] m_tuser     // [1:0] frame_status
);

    rfcc_pkg::rx_item_t   in_item;
    rfcc_pkg::rx_item_t   held_item;
    rfcc_pkg::check_res_t res;
    logic                 held_valid;
    logic                 advance;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg;
    logic       m_last_reg;
    logic [1:0] m_status_reg;

    assign in_item.rx_byte   = s_tdata;
    assign in_item.burst_end = s_tlast;

    // The held byte moves on when the result register is free or drains.
    assign advance = held_valid && (!m_valid_reg || m_tready);

    rfcc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .held_valid (held_valid),
        .held_item  (held_item),
        .advance    (advance)
    );

    rfcc_check #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_check (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (held_item),
        .res     (res)
    );

    // Result register valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload, loaded on each transfer out of the input register.
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg   <= held_item.rx_byte;
            m_last_reg   <= res.out_last;
            m_status_reg <= res.frame_status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_status_reg;

endmodule

// ===== design/rfcc_in_reg.sv =====
module rfcc_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  rfcc_pkg::rx_item_t in_item,
    output logic              held_valid,
    output rfcc_pkg::rx_item_t held_item,
    input  logic              advance
);

    logic               valid_reg;
    logic               valid_next;
    rfcc_pkg::rx_item_t item_reg;

    // The register takes a new transfer when it is empty or drains in this cycle.
    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    // Valid flag under reset; the payload needs none.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== design/rfcc_check.sv =====
module rfcc_check #(
    parameter int MAX_FRAME_BYTES = rfcc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  rfcc_pkg::rx_item_t   item,
    output rfcc_pkg::check_res_t res
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = (POS_W + 1 > 9) ? POS_W + 1 : 9;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       count_reg, count_next;
    logic [1:0]       chk_reg, chk_next;
    logic             mism_reg, mism_next;
    logic             ovr_reg, ovr_next;

    logic [7:0]       n_cur;
    logic [CMP_W-1:0] p_ext;
    logic [CMP_W-1:0] n_ext;
    logic [CMP_W-1:0] p_plus1;
    logic [CMP_W-1:0] p_plus2;
    rfcc_pkg::frame_status_t status;

    // Frame count is taken from byte 0 of the burst.
    assign n_cur   = (pos_reg == '0) ? item.rx_byte : count_reg;
    assign p_ext   = CMP_W'(pos_reg);
    assign n_ext   = CMP_W'(n_cur);
    assign p_plus1 = p_ext + CMP_W'(1);
    assign p_plus2 = p_ext + CMP_W'(2);

    // Per-byte state update: CRC over the body, compare on the two check bytes.
    always_comb begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        count_next = count_reg;
        chk_next   = chk_reg;
        mism_next  = mism_reg;
        ovr_next   = ovr_reg;
        if (pos_reg >= POS_MAX) begin
            ovr_next = 1'b1;
        end else begin
            count_next = n_cur;
            if (p_plus2 < n_ext) begin
                crc_next = rfcc_pkg::crc_feed(crc_reg, item.rx_byte);
            end else if (p_plus2 == n_ext) begin
                if (item.rx_byte != crc_reg[7:0]) begin
                    mism_next = 1'b1;
                end
                chk_next = chk_reg + 2'd1;
            end else if (p_plus1 == n_ext) begin
                if (item.rx_byte != crc_reg[15:8]) begin
                    mism_next = 1'b1;
                end
                chk_next = chk_reg + 2'd1;
            end
            pos_next = pos_reg + POS_W'(1);
        end
    end

    // Status from the updated state, in priority order.
    always_comb begin
        status = rfcc_pkg::STATUS_OK;
        if (item.burst_end) begin
            if (ovr_next) begin
                status = rfcc_pkg::STATUS_OVERRUN;
            end else if (count_next < 8'd2 || chk_next < 2'd2) begin
                status = rfcc_pkg::STATUS_LEN_ERR;
            end else if (mism_next) begin
                status = rfcc_pkg::STATUS_CRC_ERR;
            end
        end
    end

    assign res.out_last     = item.burst_end;
    assign res.frame_status = status;

    // State advances on each transfer and clears after the last byte of a burst.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            crc_reg   <= '0;
            count_reg <= '0;
            chk_reg   <= '0;
            mism_reg  <= 1'b0;
            ovr_reg   <= 1'b0;
        end else if (fire) begin
            if (item.burst_end) begin
                pos_reg   <= '0;
                crc_reg   <= '0;
                count_reg <= '0;
                chk_reg   <= '0;
                mism_reg  <= 1'b0;
                ovr_reg   <= 1'b0;
            end else begin
                pos_reg   <= pos_next;
                crc_reg   <= crc_next;
                count_reg <= count_next;
                chk_reg   <= chk_next;
                mism_reg  <= mism_next;
                ovr_reg   <= ovr_next;
            end
        end
    end

    // A burst end leaves the checker clear for the next burst.
    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.burst_end |=> pos_reg == '0 && crc_reg == '0 && !ovr_reg)
        else $error("checker state not cleared after burst end");

    // The byte position saturates at the frame limit.
    a_pos_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_MAX)
        else $error("byte position beyond frame limit");

    // At most two check bytes can be counted in one burst.
    a_chk_count: assert property (@(posedge aclk) disable iff (!aresetn)
        chk_reg != 2'd3)
        else $error("more than two check bytes counted");

    // Overrun is only reported once the limit has been reached.
    a_overrun_src: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.frame_status == rfcc_pkg::STATUS_OVERRUN |-> pos_reg == POS_MAX)
        else $error("overrun reported below the frame limit");

    // Only the last byte of a burst carries a non-zero status.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !item.burst_end |-> res.frame_status == rfcc_pkg::STATUS_OK)
        else $error("status reported on a byte that is not last");

endmodule

// ===== sim/tb.sv =====
module tb;

    localparam int FRAME_LIMIT = rfcc_pkg::MAX_FRAME_BYTES_DEF;
    localparam int ITEM_TARGET = 1000;
    localparam int CYCLE_LIMIT = 400000;

    // Shapes of generated bursts.
    typedef enum int {
        SHAPE_GOOD,
        SHAPE_BAD_CRC,
        SHAPE_SHORT,
        SHAPE_TRAILING,
        SHAPE_NOISE,
        SHAPE_OVERRUN
    } frame_shape_t;

    // Predicts the status of each received burst and holds the bytes still to come out.
    class crc_frame_scoreboard;
        typedef struct {
            logic [7:0]              data;
            logic                    last;
            rfcc_pkg::frame_status_t status;
        } checked_byte_t;

        checked_byte_t awaited_q[$];
        int            position;
        logic [15:0]   crc;
        logic [7:0]    count;
        logic [1:0]    checks;
        bit            mismatch;
        bit            overrun;
        int            errors;

        function new();
            errors = 0;
            clear_frame();
        endfunction

        // One byte of the CRC, data taken least significant bit first.
        static function logic [15:0] crc_byte_step(logic [15:0] c, logic [7:0] d);
            logic [15:0] r;
            r = c;
            for (int i = 0; i < 8; i++) begin
                r = {r[14:0], 1'b0} ^ ({16{d[i] ^ r[15]}} & rfcc_pkg::CRC_POLY);
            end
            return r;
        endfunction

        function void clear_frame();
            position = 0;
            crc      = '0;
            count    = '0;
            checks   = '0;
            mismatch = 0;
            overrun  = 0;
        endfunction

        // Advance the frame state with an accepted input transfer.
        function void note_input(logic [7:0] b, logic last);
            checked_byte_t e;
            int            n;
            if (position >= FRAME_LIMIT) begin
                overrun = 1;
            end else begin
                if (position == 0) begin
                    count = b;
                end
                n = int'(count);
                if (position < n - 2) begin
                    crc = crc_byte_step(crc, b);
                end else if (position == n - 2) begin
                    if (b != crc[7:0]) mismatch = 1;
                    checks = checks + 2'd1;
                end else if (position == n - 1) begin
                    if (b != crc[15:8]) mismatch = 1;
                    checks = checks + 2'd1;
                end
                position++;
            end
            e.data   = b;
            e.last   = last;
            e.status = rfcc_pkg::STATUS_OK;
            if (last) begin
                if (overrun) begin
                    e.status = rfcc_pkg::STATUS_OVERRUN;
                end else if (count < 8'd2 || checks < 2'd2) begin
                    e.status = rfcc_pkg::STATUS_LEN_ERR;
                end else if (mismatch) begin
                    e.status = rfcc_pkg::STATUS_CRC_ERR;
                end
                clear_frame();
            end
            awaited_q.push_back(e);
        endfunction

        // Compare an output transfer with the oldest prediction.
        function void check_result(logic [7:0] b, logic last, logic [1:0] status);
            checked_byte_t e;
            if (awaited_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected output: data %02h last %0b status %0d",
                             b, last, status);
                end
                return;
            end
            e = awaited_q.pop_front();
            if (b !== e.data || last !== e.last || status !== e.status) begin
                errors++;
                if (errors <= 10) begin
                    $display("output mismatch: expected data %02h last %0b status %s,",
                             e.data, e.last, e.status.name(),
                             " got data %02h last %0b status %0d", b, last, status);
                end
            end
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [1:0] m_tuser;

    crc_frame_scoreboard sb = new();
    int                  cycle_count = 0;
    int                  items_sent  = 0;
    int                  burst_left  = 0;
    int                  ready_hold  = 0;

    response_frame_crc_checker_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    // Clock with a period of eight units.
    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Check every output transfer.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tlast, m_tuser);
        end
    end

    // Receiver: stall density changes from span to span; a requested hold-off comes first.
    initial begin
        int stall_pct;
        int span;
        m_tready  = 1'b0;
        stall_pct = 0;
        span      = 0;
        forever begin
            @(negedge aclk);
            if (ready_hold > 0) begin
                ready_hold--;
                m_tready = 1'b0;
            end else begin
                if (span == 0) begin
                    span = $urandom_range(16, 96);
                    case ($urandom_range(0, 4))
                        0, 1: stall_pct = 0;
                        2: stall_pct = 25;
                        3: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                span--;
                m_tready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Offer one byte and wait for its transfer; gaps fall between bursts.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(b, last);
        items_sent++;
    endtask

    // Build one burst of the given shape around a frame count of n and send it.
    task automatic send_frame(input frame_shape_t shape, input int n);
        logic [7:0]  q[$];
        logic [15:0] c;
        int          len;
        int          k;
        q = {};
        if (shape == SHAPE_NOISE) begin
            len = $urandom_range(1, 10);
            repeat (len) q.push_back(8'($urandom));
        end else begin
            q.push_back(8'(n));
            for (k = 1; k < n; k++) q.push_back(8'($urandom));
            c = '0;
            for (k = 0; k < n - 2; k++) c = crc_frame_scoreboard::crc_byte_step(c, q[k]);
            // With two bytes the low check byte is the count itself.
            if (n >= 3) q[n - 2] = c[7:0];
            q[n - 1] = c[15:8];
            case (shape)
                SHAPE_BAD_CRC: begin
                    k = $urandom_range(1, n - 1);
                    q[k] = q[k] ^ (8'd1 << $urandom_range(0, 7));
                end
                SHAPE_SHORT: begin
                    len = $urandom_range(1, n - 1);
                    q = q[0:len - 1];
                end
                SHAPE_TRAILING: begin
                    repeat ($urandom_range(1, 5)) q.push_back(8'($urandom));
                end
                SHAPE_OVERRUN: begin
                    len = $urandom_range(FRAME_LIMIT + 1, FRAME_LIMIT + 40);
                    while (q.size() < len) q.push_back(8'($urandom));
                end
                default: ;
            endcase
        end
        for (k = 0; k < q.size(); k++) send_byte(q[k], k == q.size() - 1);
    endtask

    // Stop offering and wait until every predicted output has been seen.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    initial begin
        int            frame_idx;
        int            pick;
        int            n;
        frame_shape_t  shape;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        aresetn  = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed bursts: shortest frames, a bad check, lone bytes, short and long bursts.
        send_frame(SHAPE_GOOD, 2);
        send_frame(SHAPE_GOOD, 3);
        send_frame(SHAPE_GOOD, 4);
        send_frame(SHAPE_BAD_CRC, 4);
        send_byte(8'h00, 1'b1);
        send_byte(8'h01, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_frame(SHAPE_SHORT, 6);
        send_frame(SHAPE_TRAILING, 3);
        wait_drained();

        // Random bursts of all shapes, close to half of them well formed.
        frame_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            frame_idx++;
            n = ($urandom_range(0, 99) < 5) ? $urandom_range(25, 255) : $urandom_range(2, 24);
            pick = $urandom_range(0, 99);
            if (pick < 45) shape = SHAPE_GOOD;
            else if (pick < 65) shape = SHAPE_BAD_CRC;
            else if (pick < 80) shape = SHAPE_TRAILING;
            else if (pick < 90) shape = SHAPE_SHORT;
            else shape = SHAPE_NOISE;
            if (frame_idx == 15 || frame_idx == 45) begin
                shape = SHAPE_OVERRUN;
            end
            if (frame_idx == 8) begin
                // Long receiver hold-off while the sender keeps offering bytes.
                ready_hold = 300;
                burst_left = 200;
                shape      = SHAPE_GOOD;
                n          = 60;
            end
            send_frame(shape, n);
            if (frame_idx == 20) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (16) @(posedge aclk);
        if (sb.pending() != 0) begin
            $display("%0d predicted outputs never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
